// File: src/yuv_procamp_adjust_macros.svh
// Assertion macros used by the proc-amp datapath.
`ifndef YUV_PROCAMP_ADJUST_MACROS_SVH
`define YUV_PROCAMP_ADJUST_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%s failed", "label");
// Next-cycle implication checked outside reset.
`define PA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%s failed", "label");
`endif

// File: src/ypa_pkg.sv
// Package with shared types, constants and the sine table of the proc-amp.
package ypa_pkg;
  localparam int unsigned RegIdxW = 2;
  localparam logic [RegIdxW-1:0] RegContrast = 2'd0;
  localparam logic [RegIdxW-1:0] RegBright = 2'd1;
  localparam logic [RegIdxW-1:0] RegHue = 2'd2;
  localparam logic [RegIdxW-1:0] RegSat = 2'd3;
  localparam int unsigned CfgW = 12;

  typedef struct packed {
    logic [11:0] contrast;
    logic signed [7:0] bright;
    logic signed [8:0] hue;
    logic [11:0] sat;
  } cfg_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
    logic chroma;
  } pix_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } res_t;

  function automatic logic [14:0] sin_q14(input logic [6:0] k);
    logic [14:0] t [0:90];
    t = '{15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
      15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964, 15'd4240,
      15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872, 15'd6138, 15'd6402,
      15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692, 15'd7943, 15'd8192, 15'd8438,
      15'd8682, 15'd8923, 15'd9162, 15'd9397, 15'd9630, 15'd9860, 15'd10087, 15'd10311,
      15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786,
      15'd11982, 15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
      15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
      15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082,
      15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
      15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182,
      15'd16225, 15'd16262, 15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374,
      15'd16382, 15'd16384};
    return (k > 7'd90) ? 15'd0 : t[k];
  endfunction
endpackage

// File: src/yuv_procamp_adjust.sv
// Top level of the YUV proc-amp: stream ports, registers and pipeline.
// One pixel word is accepted per clock and passes five register stages (four arithmetic
// stages plus the output register) before it reaches m_tvalid and m_tdata. A stall on the
// master side freezes the whole pipeline, so throughput is one word per clock while the
// sink accepts.
module yuv_procamp_adjust (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [23:0] s_tdata,  // y_in[7:0], u_in[15:8], v_in[23:16]
  input  logic s_tuser,         // has_chroma
  output logic m_tvalid,
  input  logic m_tready,
  output logic [23:0] m_tdata,  // y_out[7:0], u_out[15:8], v_out[23:16]
  input  logic cfg_we,
  input  logic [ypa_pkg::RegIdxW-1:0] cfg_index,
  input  logic [ypa_pkg::CfgW-1:0] cfg_data
);
  import ypa_pkg::*;
  cfg_t cfg;
  pix_t pix;
  res_t res;
  logic signed [15:0] hue_sin, hue_cos;
  logic [23:0] cgain;
  logic en;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign pix = '{y: s_tdata[7:0], u: s_tdata[15:8], v: s_tdata[23:16], chroma: s_tuser};
  assign m_tdata = {res.v, res.u, res.y};

  ypa_cfg_regs u_regs (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg,
    .hue_sin, .hue_cos, .cgain);
  ypa_datapath u_dp (.clk, .rst, .en, .in_valid(s_tvalid), .pix, .cfg, .hue_sin,
    .hue_cos, .cgain, .out_valid(m_tvalid), .res);
endmodule

// File: src/ypa_cfg_regs.sv
// Configuration registers and the registered hue sine, hue cosine and chroma gain.
module ypa_cfg_regs (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [ypa_pkg::RegIdxW-1:0] cfg_index,
  input  logic [ypa_pkg::CfgW-1:0] cfg_data,
  output ypa_pkg::cfg_t cfg,
  output logic signed [15:0] hue_sin,
  output logic signed [15:0] hue_cos,
  output logic [23:0] cgain
);
  import ypa_pkg::*;
  logic signed [8:0] deg;
  logic [7:0] mag;
  logic [14:0] s_mag, c_mag;
  logic c_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.contrast <= 12'd256;
      cfg.bright <= '0;
      cfg.hue <= '0;
      cfg.sat <= 12'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegContrast: cfg.contrast <= cfg_data;
        RegBright: cfg.bright <= cfg_data[7:0];
        RegHue: cfg.hue <= cfg_data[8:0];
        RegSat: cfg.sat <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    deg = cfg.hue;
    if (deg < -9'sd180) deg = -9'sd180;
    if (deg > 9'sd180) deg = 9'sd180;
    mag = deg[8] ? 8'(-deg) : deg[7:0];
    if (mag <= 8'd90) begin
      s_mag = sin_q14(mag[6:0]);
      c_mag = sin_q14(7'(8'd90 - mag));
      c_neg = 1'b0;
    end else begin
      s_mag = sin_q14(7'(8'd180 - mag));
      c_mag = sin_q14(7'(mag - 8'd90));
      c_neg = 1'b1;
    end
  end

  // Derived values are registered and follow the configuration registers in the next cycle.
  always_ff @(posedge clk) begin
    hue_sin <= deg[8] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    hue_cos <= c_neg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
    cgain <= cfg.contrast * cfg.sat;
  end
endmodule

// File: src/ypa_datapath.sv
// Five-stage luma and chroma pipeline with a shared stall.
module ypa_datapath (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  ypa_pkg::pix_t pix,
  input  ypa_pkg::cfg_t cfg,
  input  logic signed [15:0] hue_sin,
  input  logic signed [15:0] hue_cos,
  input  logic [23:0] cgain,
  output logic out_valid,
  output ypa_pkg::res_t res
);
  import ypa_pkg::*;
  `include "yuv_procamp_adjust_macros.svh"

  logic [4:0] vld;
  pix_t p1;
  logic signed [8:0] du, dv;
  logic signed [24:0] yt1, yt2, yt3, yt4;
  logic signed [24:0] a_uc, a_vs, a_vc, a_us;
  logic signed [25:0] rot_u, rot_v;
  logic signed [50:0] pu, pv;
  logic [7:0] u4, v4, u3, v3, u2, v2;
  logic c2, c3, c4;

  function automatic logic [7:0] clamp_luma(input logic signed [24:0] t);
    if (t < 0) return 8'd0;
    if (t[24:8] > 17'sd255) return 8'd255;
    return t[15:8];
  endfunction

  function automatic logic [7:0] clamp_chroma(input logic signed [50:0] p);
    logic signed [50:0] q;
    q = p + (51'sd128 <<< 30);
    if (q < 0) return 8'd0;
    if (q[50:30] > 21'sd255) return 8'd255;
    return q[37:30];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[3:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= pix;
      du <= $signed({1'b0, pix.u}) - 9'sd128;
      dv <= $signed({1'b0, pix.v}) - 9'sd128;
      yt1 <= ($signed({17'd0, pix.y}) - 25'sd16) * $signed({13'd0, cfg.contrast})
        + (25'(cfg.bright) + 25'sd16) * 25'sd256;
      a_uc <= 25'(du * hue_cos);
      a_vs <= 25'(dv * hue_sin);
      a_vc <= 25'(dv * hue_cos);
      a_us <= 25'(du * hue_sin);
      yt2 <= yt1; u2 <= p1.u; v2 <= p1.v; c2 <= p1.chroma;
      rot_u <= 26'(a_uc) + 26'(a_vs);
      rot_v <= 26'(a_vc) - 26'(a_us);
      yt3 <= yt2; u3 <= u2; v3 <= v2; c3 <= c2;
      pu <= 51'(rot_u) * $signed({27'd0, cgain});
      pv <= 51'(rot_v) * $signed({27'd0, cgain});
      yt4 <= yt3; u4 <= u3; v4 <= v3; c4 <= c3;
      res.y <= clamp_luma(yt4);
      res.u <= c4 ? clamp_chroma(pu) : u4;
      res.v <= c4 ? clamp_chroma(pv) : v4;
    end
  end
  assign out_valid = vld[4];

  `PA_ASSERT_NEXT(a_hold, !en, $stable(vld))
  `PA_ASSERT_NEXT(a_shift, en && in_valid, vld[0])
  `PA_ASSERT_NEXT(a_res_hold, !en, $stable(res))
endmodule

// File: sim/yuv_procamp_adjust_tb.sv
// Testbench for the YUV proc-amp: directed and random pixel words checked against a predictor.
`timescale 1ns / 100ps
module yuv_procamp_adjust_tb;
  import ypa_pkg::*;

  localparam int unsigned Latency = 5;
  localparam int unsigned CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;  // y_in[7:0], u_in[15:8], v_in[23:16]
  logic s_tuser = 1'b0;       // has_chroma
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;       // y_out[7:0], u_out[15:8], v_out[23:16]
  logic cfg_we = 1'b0;
  logic [RegIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  cfg_t gains;
  res_t pending_pixels[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_cycles = 0;
  bit sink_random = 1'b1;

  yuv_procamp_adjust dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("yuv_procamp_adjust_tb: FAIL");
      $finish;
    end
  end

  function automatic int sine_of(input int k);
    int table_v [0:90] = '{0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
      2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334, 5604, 5872, 6138,
      6402, 6664, 6924, 7182, 7438, 7692, 7943, 8192, 8438, 8682, 8923, 9162, 9397,
      9630, 9860, 10087, 10311, 10531, 10749, 10963, 11174, 11381, 11585, 11786,
      11982, 12176, 12365, 12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741,
      13894, 14044, 14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191,
      15296, 15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
      16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382, 16384};
    return table_v[k];
  endfunction

  function automatic logic [7:0] clamp_q30(input longint rot, input longint gain);
    longint p;
    p = rot * gain + (longint'(128) <<< 30);
    if (p < 0) return 8'd0;
    return ((p >>> 30) > 255) ? 8'd255 : 8'(p >>> 30);
  endfunction

  function automatic res_t adjust_pixel(input pix_t px);
    res_t r;
    longint t, du, dv, con, sat;
    int deg, mag, s, c;
    con = longint'(gains.contrast);
    sat = longint'(gains.sat);
    t = (longint'(px.y) - 16) * con + (longint'(gains.bright) + 16) * 256;
    r.y = (t < 0) ? 8'd0 : (((t >>> 8) > 255) ? 8'd255 : 8'(t >>> 8));
    r.u = px.u;
    r.v = px.v;
    if (px.chroma) begin
      deg = int'(gains.hue);
      if (deg < -180) deg = -180;
      if (deg > 180) deg = 180;
      mag = (deg < 0) ? -deg : deg;
      if (mag <= 90) begin
        s = sine_of(mag);
        c = sine_of(90 - mag);
      end else begin
        s = sine_of(180 - mag);
        c = -sine_of(mag - 90);
      end
      if (deg < 0) s = -s;
      du = longint'(px.u) - 128;
      dv = longint'(px.v) - 128;
      r.u = clamp_q30(du * c + dv * s, con * sat);
      r.v = clamp_q30(dv * c - du * s, con * sat);
    end
    return r;
  endfunction

  function automatic int unsigned random_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !sink_random || (random_gap() == 0);
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'({m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]});
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_tdata);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected y %0d u %0d v %0d, got y %0d u %0d v %0d",
              want.y, want.u, want.v, got.y, got.u, got.v);
        end
      end
    end
  end

  task automatic send_pixel(input pix_t px, input bit paced);
    int unsigned gap;
    gap = paced ? random_gap() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {px.v, px.u, px.y};
    s_tuser <= px.chroma;
    do @(posedge clk); while (!s_tready);
    pending_pixels.push_back(adjust_pixel(px));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      RegContrast: gains.contrast = val;
      RegBright: gains.bright = val[7:0];
      RegHue: gains.hue = val[8:0];
      default: gains.sat = val;
    endcase
  endtask

  task automatic set_gains(input int con, input int bri, input int hue, input int sat);
    wait_drained();
    write_reg(RegContrast, CfgW'(con));
    write_reg(RegBright, CfgW'(bri));
    write_reg(RegHue, CfgW'(hue));
    write_reg(RegSat, CfgW'(sat));
    cfg_we <= 1'b0;
  endtask

  function automatic pix_t random_pixel();
    pix_t px;
    px = pix_t'(25'($urandom()));
    return px;
  endfunction

  task automatic test_edge_pixels();
    byte unsigned vals [4] = '{8'd0, 8'd16, 8'd128, 8'd255};
    set_gains(2560, 100, 180, 2560);
    foreach (vals[i]) begin
      send_pixel('{vals[i], vals[i], 8'd255 - vals[i], 1'b1}, 1'b0);
      send_pixel('{vals[i], 8'd255 - vals[i], vals[i], 1'b0}, 1'b0);
    end
    set_gains(0, -100, -180, 0);
    foreach (vals[i]) send_pixel('{vals[i], vals[i], vals[i], 1'b1}, 1'b0);
    // Out-of-range hue saturates, oversized gains and brightness are used as given.
    set_gains(4095, -128, 255, 4095);
    send_pixel('{8'd255, 8'd0, 8'd255, 1'b1}, 1'b0);
    send_pixel('{8'd0, 8'd255, 8'd0, 1'b1}, 1'b0);
    set_gains(256, 127, -256, 300);
    send_pixel('{8'd200, 8'd30, 8'd220, 1'b1}, 1'b0);
    set_gains(256, 0, 90, 256);
    send_pixel('{8'd100, 8'd30, 8'd220, 1'b1}, 1'b0);
    set_gains(256, 0, -90, 256);
    send_pixel('{8'd100, 8'd30, 8'd220, 1'b1}, 1'b0);
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 10; phase++) begin
      set_gains($urandom_range(0, 2560), $urandom_range(0, 200) - 100,
        $urandom_range(0, 360) - 180, $urandom_range(0, 2560));
      for (int i = 0; i < 100; i++) send_pixel(random_pixel(), phase % 3 != 0);
    end
    set_gains($urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 511),
      $urandom_range(0, 4095));
    for (int i = 0; i < 100; i++) send_pixel(random_pixel(), 1'b1);
  endtask

  task automatic test_backpressure();
    set_gains(384, 20, 45, 512);
    hold_cycles = 200;
    for (int i = 0; i < 100; i++) send_pixel(random_pixel(), 1'b0);
    wait_drained();
    sink_random = 1'b0;
    for (int i = 0; i < 30; i++) send_pixel(random_pixel(), 1'b0);
    sink_random = 1'b1;
  endtask

  initial begin
    gains = '{contrast: 12'd256, bright: 8'sd0, hue: 9'sd0, sat: 12'd256};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_pixel('{8'd235, 8'd60, 8'd200, 1'b1}, 1'b0);
    test_edge_pixels();
    test_random_settings();
    test_backpressure();
    wait_drained();
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("yuv_procamp_adjust_tb: PASS");
    end else begin
      $display("yuv_procamp_adjust_tb: FAIL");
    end
    $finish;
  end
endmodule

// File: yuv_procamp_adjust.f
+incdir+src
src/ypa_pkg.sv
src/ypa_cfg_regs.sv
src/ypa_datapath.sv
src/yuv_procamp_adjust.sv
sim/yuv_procamp_adjust_tb.sv
